[sv/npr_pkg.sv]
// Package with shared constants, control types and state codes of the nearest point ranker.
`default_nettype none
package npr_pkg;

  localparam int ROBOTS_PER_TEAM_DEF = 16;
  localparam int COORD_BITS_DEF      = 16;
  localparam int RANK_MAX            = 16;
  localparam int IDX_W               = 4;
  localparam int OUT_DIST_W          = 33;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

[sv/nearest_point_ranker.sv]
// Top level of the nearest point ranker: robot table, distance unit and sorting chain.
// A load beat produces no result and leaves the block ready for the next beat.
// A query scans S = min(ROBOTS_PER_TEAM, 16) slots; the scan length is set by the
// distance pipeline depth plus the travel time through the row of S cells.
// Results then leave one per cycle while out_ready is high; a query with no match
// gives a single beat with out_found low. Reset clears the presence bits
// and returns the sequencer to idle; no clearing pass is needed.
`default_nettype none
module nearest_point_ranker #(
  parameter int ROBOTS_PER_TEAM = npr_pkg::ROBOTS_PER_TEAM_DEF,
  parameter int COORD_BITS      = npr_pkg::COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic        in_team,
  input  wire logic [3:0]  in_slot,
  input  wire logic        in_slot_valid_in,
  input  wire logic [15:0] in_coord_x,
  input  wire logic [15:0] in_coord_y,
  input  wire logic [15:0] in_candidate_mask,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_robot_index,
  output logic [32:0]      out_distance_sq,
  output logic             out_found,
  output logic             out_last
);
  import npr_pkg::*;

  localparam int CB       = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int DW       = 2 * CB + 1;
  localparam int S        = (ROBOTS_PER_TEAM < RANK_MAX) ? ROBOTS_PER_TEAM : RANK_MAX;
  localparam int DEPTH    = 2 * ROBOTS_PER_TEAM;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW_RAW   = $clog2(2 * S + 5);
  localparam int CW       = (CW_RAW < 4) ? 4 : CW_RAW;
  localparam logic [CW-1:0] SCAN_END  = CW'(2 * S + 4);
  localparam logic [CW-1:0] SCAN_CNT  = CW'(S);
  localparam logic [5:0]    SLOT_LIM  = 6'(ROBOTS_PER_TEAM);
  localparam logic [AW-1:0] TEAM_BASE = AW'(ROBOTS_PER_TEAM);
  localparam logic [DW:0]   SENT      = {1'b1, {DW{1'b0}}};

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     base_r;
  logic [15:0]       mask_r;
  logic [CB-1:0]     pt_x_r, pt_y_r;
  logic [DEPTH-1:0]  pres_r;

  logic              in_fire, we, issue, qual;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [2*CB-1:0]   rd_data;
  cell_ctl_t         ctl;

  logic [DW:0]       feed_dist;
  logic [IDX_W-1:0]  feed_idx;
  logic [DW:0]       chain_d [0:S-1];
  logic [IDX_W-1:0]  chain_i [0:S-1];
  logic [DW:0]       nb_d [0:S];
  logic [IDX_W-1:0]  nb_i [0:S];

  assign in_fire  = in_valid && in_ready;
  assign we       = in_fire && (in_mode == MODE_LOAD) && ({2'b00, in_slot} < SLOT_LIM);
  assign wr_addr  = in_team ? TEAM_BASE + AW'(in_slot) : AW'(in_slot);
  assign issue    = (state_r == ST_SCAN) && (cnt_r < SCAN_CNT);
  assign rd_addr  = issue ? base_r + AW'(cnt_r) : base_r;
  assign qual     = issue && mask_r[cnt_r[3:0]] && pres_r[rd_addr];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctl.clear  = 1'b0;
    ctl.insert = 1'b0;
    ctl.shift  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_mode == MODE_QUERY)) begin
          ctl.clear = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.insert = 1'b1;
        cnt_nxt    = cnt_r + CW'(1);
        if (cnt_r == SCAN_END) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        ctl.shift = out_ready;
        if (out_ready && out_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pres_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (we) begin
        pres_r[wr_addr] <= in_slot_valid_in;
      end
    end
    if (in_fire && (in_mode == MODE_QUERY)) begin
      base_r <= in_team ? TEAM_BASE : '0;
      mask_r <= in_candidate_mask;
      pt_x_r <= in_coord_x[CB-1:0];
      pt_y_r <= in_coord_y[CB-1:0];
    end
  end

  npr_ram #(
    .WIDTH (2 * CB),
    .DEPTH (DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata ({in_coord_x[CB-1:0], in_coord_y[CB-1:0]}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  npr_dist #(
    .CB (CB)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_qual (qual),
    .issue_idx  (cnt_r[3:0]),
    .pos_x      (rd_data[2*CB-1:CB]),
    .pos_y      (rd_data[CB-1:0]),
    .pt_x       (pt_x_r),
    .pt_y       (pt_y_r),
    .feed_dist  (feed_dist),
    .feed_idx   (feed_idx)
  );

  assign chain_d[0] = feed_dist;
  assign chain_i[0] = feed_idx;
  assign nb_d[S]    = SENT;
  assign nb_i[S]    = '0;

  for (genvar k = 0; k < S; k++) begin : g_cell
    if (k < S - 1) begin : g_mid
      npr_cell #(
        .DW1 (DW + 1)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .in_dist    (chain_d[k]),
        .in_idx     (chain_i[k]),
        .right_dist (nb_d[k+1]),
        .right_idx  (nb_i[k+1]),
        .held_dist  (nb_d[k]),
        .held_idx   (nb_i[k]),
        .pass_dist  (chain_d[k+1]),
        .pass_idx   (chain_i[k+1])
      );
    end else begin : g_end
      npr_cell #(
        .DW1 (DW + 1)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .in_dist    (chain_d[k]),
        .in_idx     (chain_i[k]),
        .right_dist (nb_d[k+1]),
        .right_idx  (nb_i[k+1]),
        .held_dist  (nb_d[k]),
        .held_idx   (nb_i[k]),
        .pass_dist  (),
        .pass_idx   ()
      );
    end
  end

  // The head cell holds the nearest remaining robot; an empty neighbor or empty head marks the last beat.
  assign out_found       = ~nb_d[0][DW];
  assign out_last        = nb_d[1][DW] || nb_d[0][DW];
  assign out_robot_index = out_found ? nb_i[0] : '0;
  assign out_distance_sq = out_found ? OUT_DIST_W'(nb_d[0][DW-1:0]) : '0;

endmodule
`default_nettype wire

[sv/npr_ram.sv]
// Generic single write port RAM with registered read.
`default_nettype none
module npr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[sv/npr_dist.sv]
// Pipelined squared distance unit that feeds the head of the sorting chain.
`default_nettype none
module npr_dist #(
  parameter int CB = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     issue_qual,
  input  wire logic [npr_pkg::IDX_W-1:0] issue_idx,
  input  wire logic [CB-1:0]            pos_x,
  input  wire logic [CB-1:0]            pos_y,
  input  wire logic [CB-1:0]            pt_x,
  input  wire logic [CB-1:0]            pt_y,
  output logic      [2*CB+1:0]          feed_dist,
  output logic      [npr_pkg::IDX_W-1:0] feed_idx
);
  import npr_pkg::*;

  localparam int DW = 2 * CB + 1;

  logic            qual_a_r, qual_b_r, qual_c_r, qual_d_r;
  logic [IDX_W-1:0] idx_a_r, idx_b_r, idx_c_r, idx_d_r;
  logic [CB-1:0]   adx_r, ady_r;
  logic [2*CB-1:0] sqx_r, sqy_r;
  logic [DW-1:0]   sum_r;
  logic [CB:0]     dx, dy;
  logic [CB-1:0]   adx_nxt, ady_nxt;
  logic [2*CB-1:0] sqx_nxt, sqy_nxt;
  logic [DW-1:0]   sum_nxt;

  always_comb begin
    dx      = {pos_x[CB-1], pos_x} - {pt_x[CB-1], pt_x};
    dy      = {pos_y[CB-1], pos_y} - {pt_y[CB-1], pt_y};
    adx_nxt = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady_nxt = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    sqx_nxt = (2*CB)'(adx_r) * (2*CB)'(adx_r);
    sqy_nxt = (2*CB)'(ady_r) * (2*CB)'(ady_r);
    sum_nxt = DW'(sqx_r) + DW'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qual_a_r <= 1'b0;
      qual_b_r <= 1'b0;
      qual_c_r <= 1'b0;
      qual_d_r <= 1'b0;
    end else begin
      qual_a_r <= issue_qual;
      qual_b_r <= qual_a_r;
      qual_c_r <= qual_b_r;
      qual_d_r <= qual_c_r;
    end
    idx_a_r <= issue_idx;
    idx_b_r <= idx_a_r;
    idx_c_r <= idx_b_r;
    idx_d_r <= idx_c_r;
    adx_r   <= adx_nxt;
    ady_r   <= ady_nxt;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    sum_r   <= sum_nxt;
  end

  // A slot that does not qualify enters the chain as the empty marker.
  assign feed_dist = qual_d_r ? {1'b0, sum_r} : {1'b1, {DW{1'b0}}};
  assign feed_idx  = idx_d_r;

endmodule
`default_nettype wire

[sv/npr_cell.sv]
// Systolic insertion sorter cell: on insert keeps the smaller entry and passes the larger on.
`default_nettype none
module npr_cell #(
  parameter int DW1 = 34
) (
  input  wire logic                      clk,
  input  wire npr_pkg::cell_ctl_t        ctl,
  input  wire logic [DW1-1:0]            in_dist,
  input  wire logic [npr_pkg::IDX_W-1:0] in_idx,
  input  wire logic [DW1-1:0]            right_dist,
  input  wire logic [npr_pkg::IDX_W-1:0] right_idx,
  output logic      [DW1-1:0]            held_dist,
  output logic      [npr_pkg::IDX_W-1:0] held_idx,
  output logic      [DW1-1:0]            pass_dist,
  output logic      [npr_pkg::IDX_W-1:0] pass_idx
);
  import npr_pkg::*;

  localparam logic [DW1-1:0] SENT = {1'b1, {(DW1-1){1'b0}}};

  logic [DW1-1:0]   held_dist_r, held_dist_nxt, pass_dist_r, pass_dist_nxt;
  logic [IDX_W-1:0] held_idx_r, held_idx_nxt, pass_idx_r, pass_idx_nxt;

  always_comb begin
    held_dist_nxt = held_dist_r;
    held_idx_nxt  = held_idx_r;
    pass_dist_nxt = pass_dist_r;
    pass_idx_nxt  = pass_idx_r;
    if (ctl.clear) begin
      held_dist_nxt = SENT;
      held_idx_nxt  = '0;
      pass_dist_nxt = SENT;
      pass_idx_nxt  = '0;
    end else if (ctl.insert) begin
      // On equal distance the lower slot stays ahead.
      if ((in_dist < held_dist_r) ||
          ((in_dist == held_dist_r) && (in_idx < held_idx_r))) begin
        held_dist_nxt = in_dist;
        held_idx_nxt  = in_idx;
        pass_dist_nxt = held_dist_r;
        pass_idx_nxt  = held_idx_r;
      end else begin
        pass_dist_nxt = in_dist;
        pass_idx_nxt  = in_idx;
      end
    end else if (ctl.shift) begin
      held_dist_nxt = right_dist;
      held_idx_nxt  = right_idx;
    end
  end

  always_ff @(posedge clk) begin
    held_dist_r <= held_dist_nxt;
    held_idx_r  <= held_idx_nxt;
    pass_dist_r <= pass_dist_nxt;
    pass_idx_r  <= pass_idx_nxt;
  end

  assign held_dist = held_dist_r;
  assign held_idx  = held_idx_r;
  assign pass_dist = pass_dist_r;
  assign pass_idx  = pass_idx_r;

endmodule
`default_nettype wire

[tb/tb_nearest_point_ranker.sv]
// Self-checking testbench for the nearest point ranker: loads, ranked queries, random stalls.
`timescale 1ns / 100ps
module tb_nearest_point_ranker;
  import npr_pkg::*;

  localparam int TEAM_SIZE   = ROBOTS_PER_TEAM_DEF;
  localparam int CALM_TAIL   = 20;
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 40;

  typedef struct packed {
    logic        mode;
    logic        team;
    logic [3:0]  slot;
    logic        present;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] mask;
  } robot_cmd_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [32:0] dsq;
    logic        found;
    logic        last;
  } rank_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic        in_team = 1'b0;
  logic [3:0]  in_slot = '0;
  logic        in_slot_valid_in = 1'b0;
  logic [15:0] in_coord_x = '0;
  logic [15:0] in_coord_y = '0;
  logic [15:0] in_candidate_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_robot_index;
  logic [32:0] out_distance_sq;
  logic        out_found;
  logic        out_last;

  robot_cmd_t  pending_cmds[$];
  rank_beat_t  expected_ranks[$];
  robot_cmd_t  next_cmd;
  rank_beat_t  seen_rank;

  logic signed [15:0] robot_x [0:2*TEAM_SIZE-1];
  logic signed [15:0] robot_y [0:2*TEAM_SIZE-1];
  bit                 robot_present [0:2*TEAM_SIZE-1];

  logic beat_taken = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  bit   hold_off = 1'b0;
  int   accepted_cmds = 0;
  int   fail_count = 0;

  nearest_point_ranker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_team           (in_team),
    .in_slot           (in_slot),
    .in_slot_valid_in  (in_slot_valid_in),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_candidate_mask (in_candidate_mask),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_robot_index   (out_robot_index),
    .out_distance_sq   (out_distance_sq),
    .out_found         (out_found),
    .out_last          (out_last)
  );

  always #10 clk = ~clk;

  task automatic add_load(input logic team, input logic [3:0] slot, input logic present,
                          input logic [15:0] x, input logic [15:0] y);
    robot_cmd_t c;
    c.mode    = MODE_LOAD;
    c.team    = team;
    c.slot    = slot;
    c.present = present;
    c.x       = x;
    c.y       = y;
    c.mask    = 16'($urandom);
    pending_cmds.push_back(c);
  endtask

  task automatic add_query(input logic team, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] mask);
    robot_cmd_t c;
    c.mode    = MODE_QUERY;
    c.team    = team;
    c.slot    = 4'($urandom);
    c.present = 1'($urandom);
    c.x       = x;
    c.y       = y;
    c.mask    = mask;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [15:0] pick_coord();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      1, 2, 3: v = 16'($signed($urandom_range(0, 8)) - 4);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic rank_robots(input robot_cmd_t c);
    longint     dist_list [16];
    int         slot_list [16];
    int         count;
    int         k;
    int         e;
    longint     dx;
    longint     dy;
    longint     d;
    rank_beat_t beat;
    if (c.mode == MODE_LOAD) begin
      e = c.team * TEAM_SIZE + c.slot;
      robot_x[e] = c.x;
      robot_y[e] = c.y;
      robot_present[e] = c.present;
      return;
    end
    count = 0;
    for (int i = 0; i < TEAM_SIZE; i++) begin
      e = c.team * TEAM_SIZE + i;
      if (c.mask[i] && robot_present[e]) begin
        dx = longint'(robot_x[e]) - longint'($signed(c.x));
        dy = longint'(robot_y[e]) - longint'($signed(c.y));
        d = dx * dx + dy * dy;
        k = count;
        while (k > 0 && dist_list[k-1] > d) begin
          dist_list[k] = dist_list[k-1];
          slot_list[k] = slot_list[k-1];
          k--;
        end
        dist_list[k] = d;
        slot_list[k] = i;
        count++;
      end
    end
    if (count == 0) begin
      beat.idx   = '0;
      beat.dsq   = '0;
      beat.found = 1'b0;
      beat.last  = 1'b1;
      expected_ranks.push_back(beat);
    end else begin
      for (int r = 0; r < count; r++) begin
        beat.idx   = 4'(slot_list[r]);
        beat.dsq   = 33'(dist_list[r]);
        beat.found = 1'b1;
        beat.last  = (r == count - 1);
        expected_ranks.push_back(beat);
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !beat_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      send_gap <= $urandom_range(0, 2);
      in_valid <= 1'b0;
    end else if (pending_cmds.size() != 0) begin
      next_cmd = pending_cmds.pop_front();
      in_valid          <= 1'b1;
      in_mode           <= next_cmd.mode;
      in_team           <= next_cmd.team;
      in_slot           <= next_cmd.slot;
      in_slot_valid_in  <= next_cmd.present;
      in_coord_x        <= next_cmd.x;
      in_coord_y        <= next_cmd.y;
      in_candidate_mask <= next_cmd.mask;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
      recv_gap <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_ranks.size() == 0) begin
        $error("unexpected result beat: robot_index %0d distance_sq %0d found %0b last %0b",
               out_robot_index, out_distance_sq, out_found, out_last);
        fail_count++;
      end else begin
        seen_rank = expected_ranks.pop_front();
        if (out_robot_index !== seen_rank.idx) begin
          $error("robot_index: expected %0d, actual %0d", seen_rank.idx, out_robot_index);
          fail_count++;
        end
        if (out_distance_sq !== seen_rank.dsq) begin
          $error("distance_sq: expected %0d, actual %0d", seen_rank.dsq, out_distance_sq);
          fail_count++;
        end
        if (out_found !== seen_rank.found) begin
          $error("found: expected %0b, actual %0b", seen_rank.found, out_found);
          fail_count++;
        end
        if (out_last !== seen_rank.last) begin
          $error("last: expected %0b, actual %0b", seen_rank.last, out_last);
          fail_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      rank_robots({in_mode, in_team, in_slot, in_slot_valid_in, in_coord_x, in_coord_y,
                   in_candidate_mask});
      accepted_cmds <= accepted_cmds + 1;
    end
    beat_taken <= rst_n && in_valid && in_ready;
  end

  initial begin
    while (accepted_cmds < HOLD_AFTER) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    for (int i = 0; i < 2 * TEAM_SIZE; i++) begin
      robot_x[i] = '0;
      robot_y[i] = '0;
      robot_present[i] = 1'b0;
    end

    add_load(1'b0, 4'd0, 1'b1, 16'h7FFF, 16'h7FFF);
    add_load(1'b0, 4'd15, 1'b1, 16'h8000, 16'h8000);
    add_query(1'b0, 16'h8000, 16'h8000, 16'hFFFF);
    add_load(1'b0, 4'd3, 1'b1, 16'd100, 16'd0);
    add_load(1'b0, 4'd5, 1'b1, 16'd0, 16'd100);
    add_load(1'b0, 4'd7, 1'b0, 16'd0, 16'd0);
    add_query(1'b0, 16'd0, 16'd0, 16'hFFFF);
    add_query(1'b0, 16'd0, 16'd0, 16'h0000);
    add_query(1'b1, 16'd0, 16'd0, 16'hFFFF);
    add_load(1'b1, 4'd10, 1'b1, -16'sd5, 16'd7);
    add_load(1'b1, 4'd2, 1'b1, 16'd7, -16'sd5);
    add_query(1'b1, 16'd0, 16'd0, 16'hFFFF);
    add_query(1'b1, 16'd0, 16'd0, 16'hFBFF);
    add_query(1'b0, 16'd0, 16'd0, 16'h0028);
    add_load(1'b0, 4'd0, 1'b0, 16'd0, 16'd0);
    add_query(1'b0, 16'h7FFF, 16'h8000, 16'h8001);
    add_query(1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);

    for (int n = 0; n < 100; n++) begin
      if ($urandom_range(0, 9) < 6) begin
        add_load(1'($urandom), 4'($urandom), $urandom_range(0, 4) != 0,
                 pick_coord(), pick_coord());
      end else begin
        case ($urandom_range(0, 9))
          0: add_query(1'($urandom), pick_coord(), pick_coord(), 16'h0000);
          1, 2, 3, 4: add_query(1'($urandom), pick_coord(), pick_coord(), 16'($urandom));
          default: add_query(1'($urandom), pick_coord(), pick_coord(), 16'hFFFF);
        endcase
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && expected_ranks.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
